// ===== sv/rdv_pkg.sv =====
// Package of the refraction core: beat payload types, format constants and the rounding helper.
package rdv_pkg;

  // Fraction bits of the external normal, index and output formats.
  localparam int unsigned IO_FRAC   = 14;
  // Guard bits applied to the incident length before the square root.
  localparam int unsigned LEN_GUARD = 14;
  // Saturation bounds of an output component.
  localparam int signed   OUT_MAX   = 16384;
  localparam int signed   OUT_MIN   = -16384;

  typedef struct packed {
    logic signed [15:0] inc_x;
    logic signed [15:0] inc_y;
    logic signed [15:0] inc_z;
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_z;
    logic        [15:0] index_ratio;
  } rdv_in_t;

  typedef struct packed {
    logic               refracts;
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic signed [15:0] out_z;
  } rdv_out_t;

  // Shift right by s with rounding half away from zero.
  function automatic logic signed [63:0] rnd64(input logic signed [63:0] v,
                                               input int unsigned s);
    logic signed [63:0] h;
    logic signed [63:0] t;
    h = 64'sd0;
    t = v;
    if (s != 0) begin
      h = 64'sd1 <<< (s - 1);
      t = v + h;
      if (v[63]) begin
        t = t - 64'sd1;
      end
      t = t >>> s;
    end
    return t;
  endfunction

endpackage

// ===== sv/rdv_chan_if.sv =====
// Valid/ready channel interface that carries one payload beat.
interface rdv_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/rdv_isqrt.sv =====
// Pipelined integer square root, one result bit per stage, with a travelling sideband.
module rdv_isqrt #(
  parameter int unsigned RW  = 30,
  parameter int unsigned SDW = 1
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [2*RW-1:0] x_i,
  input  logic [SDW-1:0]  side_i,
  output logic [RW-1:0]   root_o,
  output logic [RW:0]     rem_o,
  output logic [SDW-1:0]  side_o
);

  logic [2*RW-1:0] rem_q  [RW];
  logic [RW-1:0]   res_q  [RW];
  logic [SDW-1:0]  side_q [RW];

  for (genvar j = 0; j < RW; j++) begin : g_stage
    localparam int unsigned B = RW - 1 - j;
    logic [2*RW:0]   remin;
    logic [RW-1:0]   resin;
    logic [SDW-1:0]  sidein;
    logic [2*RW:0]   trial;
    logic [2*RW:0]   diff;
    logic [2*RW-1:0] rem_d;
    logic [RW-1:0]   res_d;

    if (j == 0) begin : g_first
      assign remin  = {1'b0, x_i};
      assign resin  = '0;
      assign sidein = side_i;
    end else begin : g_next
      assign remin  = {1'b0, rem_q[j-1]};
      assign resin  = res_q[j-1];
      assign sidein = side_q[j-1];
    end

    always_comb begin
      trial = ((2*RW+1)'(resin) << (B + 1)) + ((2*RW+1)'(1) << (2 * B));
      diff  = remin - trial;
      if (remin >= trial) begin
        rem_d = diff[2*RW-1:0];
        res_d = resin | (RW'(1) << B);
      end else begin
        rem_d = remin[2*RW-1:0];
        res_d = resin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j]  <= rem_d;
        res_q[j]  <= res_d;
        side_q[j] <= sidein;
      end
    end
  end

  // The final remainder never exceeds twice the root.
  assign root_o = res_q[RW-1];
  assign rem_o  = rem_q[RW-1][RW:0];
  assign side_o = side_q[RW-1];

endmodule

// ===== sv/refract_direction_vector_core.sv =====
// Top level of the pipelined Snell-law refraction core for one direction vector.
//
//   Channel | Dir | Beat payload                                   | Handshake
//   --------+-----+------------------------------------------------+------------
//   in_i    | in  | inc_x/y/z Q3.12, norm_x/y/z Q1.14, index Q2.14 | valid/ready
//   out_o   | out | refracts, out_x/y/z Q1.14                      | valid/ready
//
// One ray is taken in every clock cycle while the skid register is empty. The two bit-per-stage
// square roots and the bit-per-stage dividers make up most of the pipeline depth.
// Reset clears only the stage valid bits and the skid flag; payload registers are not reset.
// A stall at the output parks the finished beat in a skid register and freezes the whole
// pipeline until it is taken, so nothing is lost or repeated and input ready is a register.
module refract_direction_vector_core #(
  parameter int unsigned FRAC_BITS = 14
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rdv_chan_if.sink   in_i,
  rdv_chan_if.source out_o
);
  import rdv_pkg::*;

  // Widths. Every bound follows from the worst case of a non-unit normal.
  localparam int unsigned LXW = 32 + 2 * LEN_GUARD;     // guarded sum of squares
  localparam int unsigned LW  = LXW / 2;                // incident length
  localparam int unsigned DVW = LW + 1;                 // doubled divisor
  localparam int unsigned QW  = FRAC_BITS + 1;          // quotient magnitude
  localparam int unsigned DRW = FRAC_BITS + 31;         // division remainder
  localparam int unsigned UW  = FRAC_BITS + 2;          // normalized component
  localparam int unsigned PW  = UW + 16;                // u times normal
  localparam int unsigned CW  = FRAC_BITS + 4;          // cosine
  localparam int unsigned CCW = 2 * CW;                 // cosine squared, raw
  localparam int unsigned NCW = 16 + CW;                // normal times cosine, raw
  localparam int unsigned N2W = FRAC_BITS + 6;          // index squared
  localparam int unsigned OMW = FRAC_BITS + 8;          // one minus cosine squared
  localparam int unsigned PPW = N2W + OMW;              // product in the discriminant
  localparam int unsigned SW  = FRAC_BITS + 5;          // root of the discriminant
  localparam int unsigned TW  = FRAC_BITS + 7;          // tangential term
  localparam int unsigned SQW = FRAC_BITS + 7;          // rounded root, with sign bit
  localparam int unsigned AW  = 17 + TW;
  localparam int unsigned BW  = 16 + SQW;
  localparam int unsigned RW  = FRAC_BITS + 11;         // component before output rounding

  // Stage map.
  localparam int unsigned S_IN  = 0;
  localparam int unsigned S_SQ1 = S_IN + 1;
  localparam int unsigned S_DP  = S_SQ1 + LW;
  localparam int unsigned S_DV  = S_DP + 1;
  localparam int unsigned S_C1  = S_DV + QW;
  localparam int unsigned S_C6  = S_C1 + 5;
  localparam int unsigned S_SQ2 = S_C6 + 1;
  localparam int unsigned S_R1  = S_SQ2 + SW;
  localparam int unsigned S_OUT = S_R1 + 3;
  localparam int unsigned NS    = S_OUT + 1;

  typedef struct packed {
    logic             ok;
    logic [2:0][15:0] nrm;
    logic [15:0]      n;
  } side_t;

  localparam int unsigned SD1 = 1 + $bits(rdv_in_t);
  localparam int unsigned SDS = $bits(side_t);
  localparam int unsigned SD2 = 3 * TW + SDS;

  localparam logic signed [63:0] ONE = 64'sd1 <<< FRAC_BITS;

  // Pipeline control: the whole pipe advances unless the skid register is occupied.
  logic          adv;
  logic [NS-1:0] v_q;
  logic          sk_v_q;
  rdv_out_t      sk_q;
  rdv_out_t      out_q;

  assign adv        = !sk_v_q;
  assign in_i.ready = adv;
  assign out_o.valid = sk_v_q || v_q[S_OUT];
  assign out_o.data  = sk_v_q ? sk_q : out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q    <= '0;
      sk_v_q <= 1'b0;
    end else begin
      if (adv) begin
        v_q <= {v_q[NS-2:0], in_i.valid};
      end
      if (adv && v_q[S_OUT] && !out_o.ready) begin
        sk_v_q <= 1'b1;
      end else if (sk_v_q && out_o.ready) begin
        sk_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && v_q[S_OUT]) begin
      sk_q <= out_q;
    end
  end

  // Input stage: capture the ray and form the squared length.
  rdv_in_t            in_q;
  logic        [31:0] sumsq_q;
  logic        [31:0] sumsq_d;
  logic signed [31:0] px;
  logic signed [31:0] py;
  logic signed [31:0] pz;

  always_comb begin
    px      = in_i.data.inc_x * in_i.data.inc_x;
    py      = in_i.data.inc_y * in_i.data.inc_y;
    pz      = in_i.data.inc_z * in_i.data.inc_z;
    sumsq_d = 32'(px) + 32'(py) + 32'(pz);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      in_q    <= in_i.data;
      sumsq_q <= sumsq_d;
    end
  end

  // Length of the incident vector, unsigned Q4.26, with the ray riding alongside.
  logic [LW-1:0]  len;
  logic [SD1-1:0] s1_side;
  rdv_in_t        s1_in;
  logic           s1_nz;

  rdv_isqrt #(
    .RW  (LW),
    .SDW (SD1)
  ) u_len_sqrt (
    .clk_i  (clk_i),
    .en_i   (adv),
    .x_i    ({sumsq_q, {(2 * LEN_GUARD){1'b0}}}),
    .side_i ({sumsq_q != 32'd0, in_q}),
    .root_o (len),
    .rem_o  (),
    .side_o (s1_side)
  );

  assign s1_nz = s1_side[SD1-1];
  assign s1_in = rdv_in_t'(s1_side[SD1-2:0]);

  // Division set-up: magnitudes, rounding offset and doubled divisor.
  logic [DRW-1:0] dp_rem_d [3];
  logic [DRW-1:0] dp_rem_q [3];
  logic [2:0]     dp_neg_d;
  logic [2:0]     dp_neg_q;
  logic [DVW-1:0] dp_dv_q;
  side_t          dp_side_d;
  side_t          dp_side_q;
  logic [2:0][15:0] incv;
  logic [15:0]    mag [3];

  always_comb begin
    incv      = {s1_in.inc_z, s1_in.inc_y, s1_in.inc_x};
    dp_side_d = '{ok: s1_nz, nrm: {s1_in.norm_z, s1_in.norm_y, s1_in.norm_x},
                  n: s1_in.index_ratio};
    for (int i = 0; i < 3; i++) begin
      dp_neg_d[i] = incv[i][15];
      mag[i]      = incv[i][15] ? (~incv[i] + 16'd1) : incv[i];
      dp_rem_d[i] = (DRW'(mag[i]) << (FRAC_BITS + LEN_GUARD + 1)) + DRW'(len);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dp_rem_q  <= dp_rem_d;
      dp_neg_q  <= dp_neg_d;
      dp_dv_q   <= {len, 1'b0};
      dp_side_q <= dp_side_d;
    end
  end

  // Restoring dividers, one quotient bit per stage, three components side by side.
  logic [DRW-1:0] dv_rem_q  [QW][3];
  logic [QW-1:0]  dv_quo_q  [QW][3];
  logic [DVW-1:0] dv_dv_q   [QW];
  logic [2:0]     dv_neg_q  [QW];
  side_t          dv_side_q [QW];

  for (genvar j = 0; j < QW; j++) begin : g_div
    localparam int unsigned B = QW - 1 - j;
    logic [DRW-1:0] rin  [3];
    logic [QW-1:0]  qin  [3];
    logic [DRW-1:0] rout [3];
    logic [QW-1:0]  qout [3];
    logic [DVW-1:0] dvin;
    logic [2:0]     negin;
    side_t          sin;
    logic [DRW-1:0] trial;

    if (j == 0) begin : g_first
      always_comb begin
        rin   = dp_rem_q;
        qin   = '{default: '0};
        dvin  = dp_dv_q;
        negin = dp_neg_q;
        sin   = dp_side_q;
      end
    end else begin : g_next
      always_comb begin
        rin   = dv_rem_q[j-1];
        qin   = dv_quo_q[j-1];
        dvin  = dv_dv_q[j-1];
        negin = dv_neg_q[j-1];
        sin   = dv_side_q[j-1];
      end
    end

    always_comb begin
      trial = DRW'(dvin) << B;
      for (int i = 0; i < 3; i++) begin
        if (rin[i] >= trial) begin
          rout[i] = rin[i] - trial;
          qout[i] = qin[i] | (QW'(1) << B);
        end else begin
          rout[i] = rin[i];
          qout[i] = qin[i];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        dv_rem_q[j]  <= rout;
        dv_quo_q[j]  <= qout;
        dv_dv_q[j]   <= dvin;
        dv_neg_q[j]  <= negin;
        dv_side_q[j] <= sin;
      end
    end
  end

  // C1: signed unit components and their products with the normal.
  logic signed [UW-1:0] u_d  [3];
  logic signed [UW-1:0] u1_q [3];
  logic signed [PW-1:0] pr_d [3];
  logic signed [PW-1:0] pr_q [3];
  side_t                side1_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      u_d[i]  = dv_neg_q[QW-1][i] ? -$signed({1'b0, dv_quo_q[QW-1][i]})
                                  : $signed({1'b0, dv_quo_q[QW-1][i]});
      pr_d[i] = u_d[i] * $signed(dv_side_q[QW-1].nrm[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      u1_q    <= u_d;
      pr_q    <= pr_d;
      side1_q <= dv_side_q[QW-1];
    end
  end

  // C2: cosine and the raw square of the index.
  logic signed [63:0]   c64;
  logic signed [CW-1:0] c_q;
  logic        [31:0]   nn_q;
  logic signed [UW-1:0] u2_q [3];
  side_t                side2_q;

  assign c64 = rnd64(64'(pr_q[0]) + 64'(pr_q[1]) + 64'(pr_q[2]), IO_FRAC);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c_q     <= c64[CW-1:0];
      nn_q    <= 32'(side1_q.n) * 32'(side1_q.n);
      u2_q    <= u1_q;
      side2_q <= side1_q;
    end
  end

  // C3: cosine squared, normal times cosine, rounded index squared.
  logic signed [CCW-1:0] cc_d;
  logic signed [CCW-1:0] cc_q;
  logic signed [NCW-1:0] nc_d [3];
  logic signed [NCW-1:0] nc_q [3];
  logic signed [63:0]    n2_64;
  logic signed [N2W-1:0] n2_q;
  logic signed [UW-1:0]  u3_q [3];
  side_t                 side3_q;

  always_comb begin
    cc_d  = c_q * c_q;
    n2_64 = rnd64($signed({32'd0, nn_q}), 28 - FRAC_BITS);
    for (int i = 0; i < 3; i++) begin
      nc_d[i] = $signed(side2_q.nrm[i]) * c_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cc_q    <= cc_d;
      nc_q    <= nc_d;
      n2_q    <= n2_64[N2W-1:0];
      u3_q    <= u2_q;
      side3_q <= side2_q;
    end
  end

  // C4: one minus cosine squared and the tangential term u - N c.
  logic signed [63:0]    om64;
  logic signed [63:0]    t64 [3];
  logic signed [OMW-1:0] omc_q;
  logic signed [N2W-1:0] n2b_q;
  logic signed [TW-1:0]  t4_q [3];
  side_t                 side4_q;

  always_comb begin
    om64 = ONE - rnd64(64'(cc_q), FRAC_BITS);
    for (int i = 0; i < 3; i++) begin
      t64[i] = 64'(u3_q[i]) - rnd64(64'(nc_q[i]), IO_FRAC);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      omc_q   <= om64[OMW-1:0];
      n2b_q   <= n2_q;
      for (int i = 0; i < 3; i++) begin
        t4_q[i] <= t64[i][TW-1:0];
      end
      side4_q <= side3_q;
    end
  end

  // C5: index squared times one minus cosine squared.
  logic signed [PPW-1:0] p_d;
  logic signed [PPW-1:0] p_q;
  logic signed [TW-1:0]  t5_q [3];
  side_t                 side5_q;

  assign p_d = n2b_q * omc_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p_q     <= p_d;
      t5_q    <= t4_q;
      side5_q <= side4_q;
    end
  end

  // C6: discriminant, its sign and the scaled operand of the second root.
  logic signed [63:0]  d64;
  side_t               side6_d;
  side_t               side6_q;
  logic [2*SW-1:0]     x2_q;
  logic signed [TW-1:0] t6_q [3];

  always_comb begin
    d64        = ONE - rnd64(64'(p_q), FRAC_BITS);
    side6_d    = side5_q;
    side6_d.ok = side5_q.ok && (d64 > 64'sd0);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      x2_q    <= {d64[SW+4:0], {FRAC_BITS{1'b0}}};
      t6_q    <= t5_q;
      side6_q <= side6_d;
    end
  end

  // Square root of the discriminant.
  logic [SW-1:0]  root2;
  logic [SW:0]    rem2;
  logic [SD2-1:0] s2_side;
  side_t          s2_sd;
  logic signed [TW-1:0] s2_t [3];

  rdv_isqrt #(
    .RW  (SW),
    .SDW (SD2)
  ) u_disc_sqrt (
    .clk_i  (clk_i),
    .en_i   (adv),
    .x_i    (x2_q),
    .side_i ({t6_q[2], t6_q[1], t6_q[0], side6_q}),
    .root_o (root2),
    .rem_o  (rem2),
    .side_o (s2_side)
  );

  always_comb begin
    s2_sd = side_t'(s2_side[SDS-1:0]);
    for (int i = 0; i < 3; i++) begin
      s2_t[i] = s2_side[SDS + i*TW +: TW];
    end
  end

  // R1: round the root to nearest.
  logic signed [SQW-1:0] sq_q;
  logic signed [TW-1:0]  t7_q [3];
  side_t                 side7_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sq_q    <= SQW'(root2) + SQW'(rem2 > (SW+1)'(root2));
      t7_q    <= s2_t;
      side7_q <= s2_sd;
    end
  end

  // R2: n t and N sqrt(disc).
  logic signed [AW-1:0] a_d [3];
  logic signed [AW-1:0] a_q [3];
  logic signed [BW-1:0] b_d [3];
  logic signed [BW-1:0] b_q [3];
  logic                 ok8_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      a_d[i] = $signed({1'b0, side7_q.n}) * t7_q[i];
      b_d[i] = $signed(side7_q.nrm[i]) * sq_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_q   <= a_d;
      b_q   <= b_d;
      ok8_q <= side7_q.ok;
    end
  end

  // R3: the refracted component at the internal precision.
  logic signed [63:0]   r64 [3];
  logic signed [RW-1:0] r_q [3];
  logic                 ok9_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      r64[i] = rnd64(64'(a_q[i]), IO_FRAC) - rnd64(64'(b_q[i]), IO_FRAC);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        r_q[i] <= r64[i][RW-1:0];
      end
      ok9_q <= ok8_q;
    end
  end

  // Output stage: move to Q1.14, saturate, and clear everything when there is no refraction.
  logic signed [63:0] z64 [3];
  logic signed [63:0] sat [3];
  rdv_out_t           out_d;

  if (FRAC_BITS >= IO_FRAC) begin : g_narrow
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        z64[i] = rnd64(64'(r_q[i]), FRAC_BITS - IO_FRAC);
      end
    end
  end else begin : g_widen
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        z64[i] = 64'(r_q[i]) <<< (IO_FRAC - FRAC_BITS);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      priority if (z64[i] < 64'(OUT_MIN)) begin
        sat[i] = 64'(OUT_MIN);
      end else if (z64[i] > 64'(OUT_MAX)) begin
        sat[i] = 64'(OUT_MAX);
      end else begin
        sat[i] = z64[i];
      end
    end
    out_d.refracts = ok9_q;
    out_d.out_x    = ok9_q ? sat[0][15:0] : 16'sd0;
    out_d.out_y    = ok9_q ? sat[1][15:0] : 16'sd0;
    out_d.out_z    = ok9_q ? sat[2][15:0] : 16'sd0;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

`ifndef SYNTHESIS
  a_clear_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.data.refracts |->
      out_o.data.out_x == 16'sd0 && out_o.data.out_y == 16'sd0 &&
      out_o.data.out_z == 16'sd0)
    else $error("clear beat carries a nonzero component");

  a_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |->
      out_o.data.out_x >= -16'sd16384 && out_o.data.out_x <= 16'sd16384 &&
      out_o.data.out_y >= -16'sd16384 && out_o.data.out_y <= 16'sd16384 &&
      out_o.data.out_z >= -16'sd16384 && out_o.data.out_z <= 16'sd16384)
    else $error("output component outside the unit range");

  a_skid_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(sk_v_q) |-> $past(v_q[S_OUT] && !out_o.ready))
    else $error("skid register filled without a stalled output beat");

  a_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sk_v_q |=> $stable(v_q))
    else $error("pipeline moved while the skid register was occupied");
`endif

endmodule
